// ----- rtl/blsa_pkg.sv -----
`timescale 1ns / 1ps

package blsa_pkg;

  // Address width of the tiled and linear spaces; addresses wrap at 2^ADDR_W.
  localparam int ADDR_W = 32;
  // Width of the unwrapped intermediate sums (covers the largest GOB offset).
  localparam int CALC_W = 40;
  // Width of the reported address ports.
  localparam int OUT_W  = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CB_WIDTH_LOG2  = 3'd2;
  localparam logic [2:0] REG_CB_HEIGHT_LOG2 = 3'd3;
  localparam logic [2:0] REG_ELEM_LOG2      = 3'd4;
  localparam logic [2:0] REG_LAYOUT_MODE    = 3'd5;
  localparam logic [2:0] REG_PITCH_ROUND    = 3'd6;
  localparam logic [2:0] REG_GOB_STACK_LOG2 = 3'd7;

  localparam logic LAYOUT_BLOCK = 1'b0;
  localparam logic LAYOUT_PITCH = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ADDR_W:0]   addr_end_t;
  typedef logic [CALC_W-1:0] calc_t;
  typedef logic [OUT_W-1:0]  out_addr_t;

  // Surface geometry derived from the configuration registers
  typedef struct packed {
    logic         mode;
    logic [2:0]   bpp_log2;
    logic [2:0]   gs_log2;
    logic [14:0]  wb;
    logic [19:0]  pitch;
    logic [13:0]  gobs;
    addr_t        size;
  } geom_t;

endpackage

// ----- rtl/blsa_cfg.sv -----
`timescale 1ns / 1ps

module blsa_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output blsa_pkg::geom_t    geom
);

  logic [14:0] surface_width;
  logic [14:0] surface_height;
  logic [1:0]  cb_width_log2;
  logic [1:0]  cb_height_log2;
  logic [2:0]  elem_log2;
  logic        layout_mode;
  logic        pitch_round;
  logic [2:0]  gob_stack_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= 15'd1;
      surface_height <= 15'd1;
      cb_width_log2  <= 2'd2;
      cb_height_log2 <= 2'd2;
      elem_log2      <= 3'd3;
      layout_mode    <= blsa_pkg::LAYOUT_BLOCK;
      pitch_round    <= 1'b1;
      gob_stack_log2 <= 3'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        blsa_pkg::REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        blsa_pkg::REG_SURFACE_HEIGHT: surface_height <= cfg_data;
        blsa_pkg::REG_CB_WIDTH_LOG2:  cb_width_log2  <= cfg_data[1:0];
        blsa_pkg::REG_CB_HEIGHT_LOG2: cb_height_log2 <= cfg_data[1:0];
        blsa_pkg::REG_ELEM_LOG2:      elem_log2      <= cfg_data[2:0];
        blsa_pkg::REG_LAYOUT_MODE:    layout_mode    <= cfg_data[0];
        blsa_pkg::REG_PITCH_ROUND:    pitch_round    <= cfg_data[0];
        blsa_pkg::REG_GOB_STACK_LOG2: gob_stack_log2 <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // First level: shifts, adds and rounding
  logic [2:0]  bpp_sat;
  logic [2:0]  gs_sat;
  logic [15:0] wb_sum;
  logic [15:0] hb_sum;
  logic [14:0] wb_c;
  logic [15:0] hb_c;
  logic [19:0] row_bytes;
  logic [19:0] pitch_pl;
  logic [19:0] pitch_bl;
  logic [15:0] hb_mask;
  logic [15:0] hb_bl;

  always_comb begin
    bpp_sat   = (elem_log2 > 3'd4) ? 3'd4 : elem_log2;
    gs_sat    = (gob_stack_log2 > 3'd4) ? 3'd4 : gob_stack_log2;
    wb_sum    = {1'b0, surface_width} + ((16'd1 << cb_width_log2) - 16'd1);
    hb_sum    = {1'b0, surface_height} + ((16'd1 << cb_height_log2) - 16'd1);
    wb_c      = 15'(wb_sum >> cb_width_log2);
    hb_c      = hb_sum >> cb_height_log2;
    row_bytes = 20'(wb_c) << bpp_sat;
    pitch_pl  = pitch_round ? ((row_bytes + 20'd31) & ~20'd31) : row_bytes;
    pitch_bl  = (row_bytes + 20'd63) & ~20'd63;
    // block height in rows is 8 << gob stack
    hb_mask   = (16'd1 << (4'd3 + 4'(gs_sat))) - 16'd1;
    hb_bl     = (hb_c + hb_mask) & ~hb_mask;
  end

  logic [15:0] hb_eff;

  // Second level: surface size, one multiply
  blsa_pkg::calc_t size_prod;
  assign size_prod = blsa_pkg::calc_t'(geom.pitch) * blsa_pkg::calc_t'(hb_eff);

  always_ff @(posedge clk) begin
    geom.mode     <= layout_mode;
    geom.bpp_log2 <= bpp_sat;
    geom.gs_log2  <= gs_sat;
    geom.wb       <= wb_c;
    geom.pitch    <= (layout_mode == blsa_pkg::LAYOUT_PITCH) ? pitch_pl : pitch_bl;
    geom.gobs     <= 14'((row_bytes + 20'd63) >> 6);
    hb_eff        <= (layout_mode == blsa_pkg::LAYOUT_PITCH) ? hb_c : hb_bl;
    geom.size     <= blsa_pkg::addr_t'(size_prod);
  end

endmodule

// ----- rtl/block_linear_swizzle_address.sv -----
`timescale 1ns / 1ps

// Swizzle address generator for a texture copy engine.
// Input channel (in_valid/in_ready): column and row of one element in
// compression-block units, plus direction (1 = linear to tiled, 0 = back).
// Output channel (out_valid/out_ready): source and destination byte
// addresses and in_bounds, which says the element end fits in the tiled
// surface. Tiled layout is pitch-linear or block-linear with 64x8 GOBs.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
// the user must write only while no transfer is in flight, which the block
// does not enforce. Derived geometry is registered, the size after a multiply.
// Throughput: one transfer per cycle while the output is not stalled; each
// input passes the input register, multiply stage and result register.
// Stall: the three stages advance together; when out_valid is high and
// out_ready low, the pipeline holds and in_ready drops in the same cycle.
// Reset (rst, synchronous): stage valids clear, config registers return to
// their defaults (1x1 surface, 4x4 blocks, 8-byte elements, block-linear, 16 GOBs).
module block_linear_swizzle_address (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] column,
  input  logic [13:0] row,
  input  logic        direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] source_address,
  output logic [31:0] destination_address,
  output logic        in_bounds
);

  blsa_pkg::geom_t geom;

  blsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // whole pipe moves when the result register is free or being drained
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---- stage A: input register
  logic        a_valid;
  logic [13:0] a_col;
  logic [13:0] a_row;
  logic        a_dir;

  // ---- stage B: products
  logic        b_valid;
  logic [13:0] b_col;
  logic [13:0] b_row;
  logic        b_dir;
  logic [28:0] lin_p;     // row * width in blocks
  logic [33:0] pl_p;      // row * pitch
  logic [24:0] bl_p;      // block row * GOBs per row

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  logic [10:0] blk_row;
  assign blk_row = 11'(a_row >> (4'd3 + 4'(geom.gs_log2)));

  always_ff @(posedge clk) begin
    if (advance) begin
      a_col <= column;
      a_row <= row;
      a_dir <= direction;
      b_col <= a_col;
      b_row <= a_row;
      b_dir <= a_dir;
      lin_p <= 29'(a_row) * 29'(geom.wb);
      pl_p  <= 34'(a_row) * 34'(geom.pitch);
      bl_p  <= 25'(blk_row) * 25'(geom.gobs);
    end
  end

  // ---- stage C: address composition and bounds check
  logic [17:0]          xb;
  blsa_pkg::calc_t      linear_c;
  blsa_pkg::calc_t      tiled_pl;
  blsa_pkg::calc_t      gob_base;
  blsa_pkg::calc_t      tiled_bl;
  logic [4:0]           bh_mask;
  logic [3:0]           y_in_blk;
  logic [8:0]           in_gob;
  blsa_pkg::addr_t      tiled;
  blsa_pkg::addr_t      linear;
  blsa_pkg::addr_end_t  tiled_end;
  logic                 bounds_ok;

  always_comb begin
    xb       = 18'(b_col) << geom.bpp_log2;
    linear_c = (blsa_pkg::calc_t'(lin_p) + blsa_pkg::calc_t'(b_col)) << geom.bpp_log2;
    tiled_pl = blsa_pkg::calc_t'(pl_p) + blsa_pkg::calc_t'(xb);
    // block-row base plus GOB index across the row, scaled by the 512-byte GOB times stack height
    gob_base = (blsa_pkg::calc_t'(bl_p) + blsa_pkg::calc_t'(xb[17:6]))
               << (4'd9 + 4'(geom.gs_log2));
    bh_mask  = (5'd1 << geom.gs_log2) - 5'd1;
    y_in_blk = b_row[6:3] & bh_mask[3:0];
    // byte within the GOB: x[5], y[2:1], x[4], y[0], x[3:0]
    in_gob   = {xb[5], b_row[2:1], xb[4], b_row[0], xb[3:0]};
    tiled_bl = gob_base + (blsa_pkg::calc_t'(y_in_blk) << 9)
               + blsa_pkg::calc_t'(in_gob);
    tiled    = blsa_pkg::addr_t'((geom.mode == blsa_pkg::LAYOUT_PITCH) ? tiled_pl
                                                                       : tiled_bl);
    linear   = blsa_pkg::addr_t'(linear_c);
    // element end is not wrapped again
    tiled_end = blsa_pkg::addr_end_t'(tiled)
                + (blsa_pkg::addr_end_t'(1) << geom.bpp_log2);
    bounds_ok = tiled_end <= blsa_pkg::addr_end_t'(geom.size);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      source_address      <= blsa_pkg::out_addr_t'(b_dir ? linear : tiled);
      destination_address <= blsa_pkg::out_addr_t'(b_dir ? tiled : linear);
      in_bounds           <= bounds_ok;
    end
  end

endmodule
